### rtl/voc_pkg.sv
// shared types and constants of the obstacle collision block
// no dependencies
`default_nettype none
package voc_pkg;

   // request kinds carried in tuser
   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_HALF_LENGTH = 2'd0,
      CSR_HALF_WIDTH  = 2'd1,
      CSR_PIVOT       = 2'd2,
      CSR_COUNT       = 2'd3
   } csr_type;

   // back end sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_VEH,
      ST_VWAIT,
      ST_CMUL,
      ST_CADD,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   // one decoded request as queued between front and back
   typedef struct packed {
      cmd_type            cmd;
      logic [5:0]         slot;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_z;
      logic [11:0]        heading;
      logic [15:0]        half_length;
      logic [15:0]        half_width;
   } item_type;

   localparam int SIN_LAT    = 5;
   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_DATA_W = 16;

endpackage
`default_nettype wire

### rtl/vehicle_obstacle_obb_collision_top.sv
// top level of the vehicle versus obstacle rectangle collision block
// depends on voc_pkg, voc_front, voc_back
`default_nettype none
// Loads write one obstacle rectangle into the table and give no response;
// a query places the vehicle box from its pivot pose and tests table slots
// 0 to min(count, MAX_OBSTACLES)-1 with the separating axis test on four
// axes, answering one collides flag. A query reads the table one slot per
// cycle into a fully pipelined sine and multiply path, after a setup that
// finds the vehicle heading and center, and ends once that path has drained.
// Items wait in a two entry queue while the back end is busy, and a finished
// flag waits in the output register without blocking the next item, though a
// query cannot finish until the flag before it is taken. Reading a slot that
// was never loaded gives an undefined answer; table contents are not cleared.
module vehicle_obstacle_obb_collision_top #(
   parameter int MAX_OBSTACLES = 64,
   parameter int HEADING_BITS  = 12
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // slot[5:0] pos_x[29:6] pos_z[53:30] heading[65:54]
   // half_length[81:66] half_width[97:82], zero padding above
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [voc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // action[0]
   input  wire logic [0:0]                       req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // collides[0], zero padding above
   output logic [voc_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  wire logic                             csr_we,
   input  wire logic [1:0]                       csr_index,
   input  wire logic [voc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic              q_valid, q_ready, collides;
   voc_pkg::item_type q_item;

   // front: decode and queue
   voc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_item     (q_item)
   );

   // back: table and collision test
   voc_back #(
      .MAX_OBSTACLES (MAX_OBSTACLES),
      .HEADING_BITS  (HEADING_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_ready      (q_ready),
      .q_item       (q_item),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_collides (collides)
   );

   assign rsp_tdata = {{(voc_pkg::RSP_DATA_W-1){1'b0}}, collides};

endmodule
`default_nettype wire

### rtl/voc_sine.sv
// pipelined fixed point sine, Q1.14 out, 16 bit phase in
// no dependencies
`default_nettype none
module voc_sine (
   input  wire logic               clock,
   input  wire logic [15:0]        phase,
   output logic signed [15:0]      sine
);

   logic [16:0] t_ff, t1_ff, t2t_ff, t3_ff;
   logic        neg_ff, neg1_ff, neg2_ff, neg3_ff;
   logic [17:0] sq_ff, sq2_ff;
   logic [15:0] inner_ff;
   logic [16:0] mid_ff;
   logic signed [15:0] sine_ff;

   logic [16:0] t_in;
   logic [15:0] tq;
   logic [33:0] sq_full;
   logic [30:0] c_full;
   logic [33:0] m_full;
   logic [33:0] p_full;
   logic [15:0] s_raw;
   logic [14:0] s_clip;

   // fold quadrant: odd quadrants mirror the position
   always_comb begin
      tq      = {phase[13:0], 2'b00};
      t_in    = phase[14] ? (17'd65536 - 17'(tq)) : 17'(tq);
      sq_full = t_ff * t_ff;
      c_full  = 31'd4640 * 31'(sq_ff);
      m_full  = 34'(sq2_ff) * 34'(inner_ff);
      p_full  = 34'(t3_ff) * 34'(mid_ff);
      s_raw   = p_full[33:18];
      s_clip  = (s_raw > 16'd16384) ? 15'd16384 : s_raw[14:0];
   end

   // polynomial stages: a fold register, then one multiply in each later stage
   always_ff @(posedge clock) begin
      t_ff     <= t_in;
      neg_ff   <= phase[15];
      sq_ff    <= sq_full[33:16];
      t1_ff    <= t_ff;
      neg1_ff  <= neg_ff;
      inner_ff <= 16'(17'd42047 - 17'(c_full[30:16]));
      sq2_ff   <= sq_ff;
      t2t_ff   <= t1_ff;
      neg2_ff  <= neg1_ff;
      mid_ff   <= 17'(18'd102944 - 18'(m_full[33:16]));
      t3_ff    <= t2t_ff;
      neg3_ff  <= neg2_ff;
      sine_ff  <= neg3_ff ? -16'(s_clip) : 16'(s_clip);
   end

   assign sine = sine_ff;

endmodule
`default_nettype wire

### rtl/voc_front.sv
// request front end: decodes stream items into a two entry queue
// depends on voc_pkg
`default_nettype none
module voc_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [voc_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire logic [0:0]                        req_tuser,
   output logic                                   q_valid,
   input  wire logic                              q_ready,
   output voc_pkg::item_type                      q_item
);

   voc_pkg::item_type fifo_ff [2];
   voc_pkg::item_type item_in;
   logic       wr_ptr_ff, rd_ptr_ff, wr_ptr_in, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   // unpack and classify the request
   always_comb begin
      item_in.cmd         = req_tuser[0] ? voc_pkg::CMD_QUERY : voc_pkg::CMD_LOAD;
      item_in.slot        = req_tdata[5:0];
      item_in.pos_x       = req_tdata[29:6];
      item_in.pos_z       = req_tdata[53:30];
      item_in.heading     = req_tdata[65:54];
      item_in.half_length = req_tdata[81:66];
      item_in.half_width  = req_tdata[97:82];
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign q_valid    = (cnt_ff != 2'd0);
   assign q_item     = fifo_ff[rd_ptr_ff];
   assign push       = req_tvalid & req_tready;
   assign pop        = q_valid & q_ready;

   // queue pointers
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule
`default_nettype wire

### rtl/voc_back.sv
// back end: obstacle table, query sequencer and separating axis pipeline
// depends on voc_pkg and voc_sine
`default_nettype none
module voc_back #(
   parameter int MAX_OBSTACLES = 64,
   parameter int HEADING_BITS  = 12
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            q_valid,
   output logic                                 q_ready,
   input  wire voc_pkg::item_type               q_item,
   input  wire logic                            csr_we,
   input  wire logic [1:0]                      csr_index,
   input  wire logic [voc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic                                 rsp_collides
);

   localparam int AW   = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
   localparam int CW0  = $clog2(MAX_OBSTACLES + 1);
   localparam int NW   = (CW0 > 7) ? CW0 : 7;
   localparam int LAT  = voc_pkg::SIN_LAT;
   localparam logic [15:0] HMASK = 16'((32'd1 << HEADING_BITS) - 1);

   // configuration registers
   logic [15:0]        hla_ff, hwa_ff;
   logic signed [15:0] pivot_ff;
   logic [6:0]         count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hla_ff   <= '0;
         hwa_ff   <= '0;
         pivot_ff <= '0;
         count_ff <= '0;
      end else if (csr_we) begin
         unique case (voc_pkg::csr_type'(csr_index))
            voc_pkg::CSR_HALF_LENGTH: hla_ff   <= csr_wdata;
            voc_pkg::CSR_HALF_WIDTH:  hwa_ff   <= csr_wdata;
            voc_pkg::CSR_PIVOT:       pivot_ff <= csr_wdata;
            voc_pkg::CSR_COUNT:       count_ff <= csr_wdata[6:0];
            default:                  hla_ff   <= hla_ff;
         endcase
      end
   end

   function automatic logic [15:0] to_phase(input logic [11:0] h);
      logic [15:0] hx;
      hx = 16'(h) & HMASK;
      return hx << (16 - HEADING_BITS);
   endfunction

   // sequencer state
   voc_pkg::state_type state_ff, state_in;
   logic [NW-1:0]  issue_ff, issue_in, n_ff, n_in;
   logic [2:0]     wait_ff, wait_in;
   logic           hit_ff, hit_in;
   logic           rsp_v_ff, rsp_v_in, rsp_c_ff, rsp_c_in;
   logic           mem_we, rd_en, busy;

   // query operands
   logic [15:0]        pa_ff;
   logic signed [23:0] vx_ff, vz_ff;
   logic signed [15:0] ca_ff, sa_ff;
   logic signed [31:0] cpx_ff, cpz_ff;
   logic signed [24:0] ax_ff, az_ff;

   // obstacle table
   logic [91:0] mem [MAX_OBSTACLES];
   logic [91:0] rd_ff;
   logic        rd_v_ff;

   // sine units: 0 and 1 obstacle or vehicle heading, 2 and 3 heading difference
   logic [15:0]        pb, dp, ph0, ph1;
   logic signed [15:0] s0, s1, s2, s3;

   assign pb  = to_phase(rd_ff[91:80]);
   assign dp  = pb - pa_ff;
   assign ph0 = (state_ff == voc_pkg::ST_VEH) ? pa_ff + 16'd16384 : pb + 16'd16384;
   assign ph1 = (state_ff == voc_pkg::ST_VEH) ? pa_ff : pb;

   voc_sine u_sin0 (.clock(clock), .phase(ph0),            .sine(s0));
   voc_sine u_sin1 (.clock(clock), .phase(ph1),            .sine(s1));
   voc_sine u_sin2 (.clock(clock), .phase(dp + 16'd16384), .sine(s2));
   voc_sine u_sin3 (.clock(clock), .phase(dp),             .sine(s3));

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      issue_in = issue_ff;
      n_in     = n_ff;
      wait_in  = wait_ff;
      hit_in   = hit_ff;
      rsp_v_in = rsp_v_ff & ~rsp_tready;
      rsp_c_in = rsp_c_ff;
      q_ready  = 1'b0;
      mem_we   = 1'b0;
      rd_en    = 1'b0;
      unique case (state_ff)
         voc_pkg::ST_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               if (q_item.cmd == voc_pkg::CMD_LOAD) begin
                  mem_we = (32'(q_item.slot) < MAX_OBSTACLES);
               end else begin
                  n_in     = (NW'(count_ff) < NW'(MAX_OBSTACLES)) ?
                             NW'(count_ff) : NW'(MAX_OBSTACLES);
                  issue_in = '0;
                  hit_in   = 1'b0;
                  state_in = voc_pkg::ST_VEH;
               end
            end
         end
         voc_pkg::ST_VEH: begin
            wait_in  = 3'd0;
            state_in = voc_pkg::ST_VWAIT;
         end
         voc_pkg::ST_VWAIT: begin
            wait_in = wait_ff + 3'd1;
            if (wait_ff == 3'(LAT - 1)) begin
               state_in = voc_pkg::ST_CMUL;
            end
         end
         voc_pkg::ST_CMUL: begin
            state_in = voc_pkg::ST_CADD;
         end
         voc_pkg::ST_CADD: begin
            state_in = voc_pkg::ST_SCAN;
         end
         voc_pkg::ST_SCAN: begin
            if (issue_ff == n_ff) begin
               state_in = voc_pkg::ST_DRAIN;
            end else begin
               rd_en    = 1'b1;
               issue_in = issue_ff + NW'(1);
            end
         end
         voc_pkg::ST_DRAIN: begin
            if (!busy && (!rsp_v_ff || rsp_tready)) begin
               rsp_v_in = 1'b1;
               rsp_c_in = hit_ff;
               state_in = voc_pkg::ST_IDLE;
            end
         end
         default: state_in = voc_pkg::ST_IDLE;
      endcase
   end

   // control registers
   logic ovl_v_ff, ovl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= voc_pkg::ST_IDLE;
         issue_ff <= '0;
         n_ff     <= '0;
         wait_ff  <= '0;
         hit_ff   <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         issue_ff <= issue_in;
         n_ff     <= n_in;
         wait_ff  <= wait_in;
         hit_ff   <= hit_in | (ovl_v_ff & ovl_ff & (state_ff != voc_pkg::ST_IDLE));
         rsp_v_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_c_ff <= rsp_c_in;
   end

   assign rsp_tvalid   = rsp_v_ff;
   assign rsp_collides = rsp_c_ff;

   // table write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[AW'(q_item.slot)] <= {q_item.heading, q_item.half_width, q_item.half_length,
                                   q_item.pos_z, q_item.pos_x};
      end
      if (rd_en) begin
         rd_ff <= mem[issue_ff[AW-1:0]];
      end
   end

   // vehicle pose and center
   always_ff @(posedge clock) begin
      if (state_ff == voc_pkg::ST_IDLE && q_valid && q_item.cmd == voc_pkg::CMD_QUERY) begin
         pa_ff <= to_phase(q_item.heading);
         vx_ff <= q_item.pos_x;
         vz_ff <= q_item.pos_z;
      end
      if (state_ff == voc_pkg::ST_VWAIT) begin
         ca_ff <= s0;
         sa_ff <= s1;
      end
      if (state_ff == voc_pkg::ST_CMUL) begin
         cpx_ff <= ca_ff * pivot_ff;
         cpz_ff <= sa_ff * pivot_ff;
      end
      if (state_ff == voc_pkg::ST_CADD) begin
         ax_ff <= 25'(vx_ff) + 25'(cpx_ff >>> 14);
         az_ff <= 25'(vz_ff) + 25'(cpz_ff >>> 14);
      end
   end

   // delay line beside the sine units
   logic               dl_v_ff  [LAT];
   logic signed [25:0] dl_dx_ff [LAT];
   logic signed [25:0] dl_dz_ff [LAT];
   logic [15:0]        dl_hl_ff [LAT];
   logic [15:0]        dl_hw_ff [LAT];
   logic signed [25:0] dx_in, dz_in;
   logic [LAT-1:0]     dl_busy;

   assign dx_in = 26'(signed'(rd_ff[23:0])) - 26'(ax_ff);
   assign dz_in = 26'(signed'(rd_ff[47:24])) - 26'(az_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff <= 1'b0;
         for (int i = 0; i < LAT; i++) begin
            dl_v_ff[i] <= 1'b0;
         end
      end else begin
         rd_v_ff    <= rd_en;
         dl_v_ff[0] <= rd_v_ff;
         for (int i = 1; i < LAT; i++) begin
            dl_v_ff[i] <= dl_v_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      dl_dx_ff[0] <= dx_in;
      dl_dz_ff[0] <= dz_in;
      dl_hl_ff[0] <= rd_ff[63:48];
      dl_hw_ff[0] <= rd_ff[79:64];
      for (int i = 1; i < LAT; i++) begin
         dl_dx_ff[i] <= dl_dx_ff[i-1];
         dl_dz_ff[i] <= dl_dz_ff[i-1];
         dl_hl_ff[i] <= dl_hl_ff[i-1];
         dl_hw_ff[i] <= dl_hw_ff[i-1];
      end
   end

   always_comb begin
      for (int i = 0; i < LAT; i++) begin
         dl_busy[i] = dl_v_ff[i];
      end
   end

   // product stage
   logic [14:0] cd, sd;
   logic signed [25:0] dx, dz;
   logic m_v_ff;
   logic signed [41:0] p_dxca_ff, p_dzsa_ff, p_dzca_ff, p_dxsa_ff;
   logic signed [41:0] p_dxcb_ff, p_dzsb_ff, p_dzcb_ff, p_dxsb_ff;
   logic [30:0] p_locd_ff, p_wosd_ff, p_losd_ff, p_wocd_ff;
   logic [30:0] p_lacd_ff, p_wasd_ff, p_lasd_ff, p_wacd_ff;
   logic [15:0] m_hl_ff, m_hw_ff;

   assign cd = s2[15] ? 15'(-s2) : 15'(s2);
   assign sd = s3[15] ? 15'(-s3) : 15'(s3);
   assign dx = dl_dx_ff[LAT-1];
   assign dz = dl_dz_ff[LAT-1];

   always_ff @(posedge clock) begin
      p_dxca_ff <= 42'(dx) * 42'(ca_ff);
      p_dzsa_ff <= 42'(dz) * 42'(sa_ff);
      p_dzca_ff <= 42'(dz) * 42'(ca_ff);
      p_dxsa_ff <= 42'(dx) * 42'(sa_ff);
      p_dxcb_ff <= 42'(dx) * 42'(s0);
      p_dzsb_ff <= 42'(dz) * 42'(s1);
      p_dzcb_ff <= 42'(dz) * 42'(s0);
      p_dxsb_ff <= 42'(dx) * 42'(s1);
      p_locd_ff <= 31'(dl_hl_ff[LAT-1]) * 31'(cd);
      p_wosd_ff <= 31'(dl_hw_ff[LAT-1]) * 31'(sd);
      p_losd_ff <= 31'(dl_hl_ff[LAT-1]) * 31'(sd);
      p_wocd_ff <= 31'(dl_hw_ff[LAT-1]) * 31'(cd);
      p_lacd_ff <= 31'(hla_ff) * 31'(cd);
      p_wasd_ff <= 31'(hwa_ff) * 31'(sd);
      p_lasd_ff <= 31'(hla_ff) * 31'(sd);
      p_wacd_ff <= 31'(hwa_ff) * 31'(cd);
      m_hl_ff   <= dl_hl_ff[LAT-1];
      m_hw_ff   <= dl_hw_ff[LAT-1];
   end

   // axis sums: distance and extent per axis
   logic signed [42:0] d0, d1, d2, d3;
   logic [42:0] dist_ff [4];
   logic [32:0] ext_ff [4];
   logic s_v_ff;

   assign d0 = 43'(p_dxca_ff) + 43'(p_dzsa_ff);
   assign d1 = 43'(p_dzca_ff) - 43'(p_dxsa_ff);
   assign d2 = 43'(p_dxcb_ff) + 43'(p_dzsb_ff);
   assign d3 = 43'(p_dzcb_ff) - 43'(p_dxsb_ff);

   always_ff @(posedge clock) begin
      dist_ff[0] <= d0[42] ? 43'(-d0) : 43'(d0);
      dist_ff[1] <= d1[42] ? 43'(-d1) : 43'(d1);
      dist_ff[2] <= d2[42] ? 43'(-d2) : 43'(d2);
      dist_ff[3] <= d3[42] ? 43'(-d3) : 43'(d3);
      ext_ff[0]  <= 33'({hla_ff, 14'd0}) + 33'(p_locd_ff) + 33'(p_wosd_ff);
      ext_ff[1]  <= 33'({hwa_ff, 14'd0}) + 33'(p_losd_ff) + 33'(p_wocd_ff);
      ext_ff[2]  <= 33'(p_lacd_ff) + 33'(p_wasd_ff) + 33'({m_hl_ff, 14'd0});
      ext_ff[3]  <= 33'(p_lasd_ff) + 33'(p_wacd_ff) + 33'({m_hw_ff, 14'd0});
   end

   // separation check: touching counts as overlap
   logic [3:0] sep;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         sep[i] = dist_ff[i] > 43'(ext_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      ovl_ff <= ~|sep;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff   <= 1'b0;
         s_v_ff   <= 1'b0;
         ovl_v_ff <= 1'b0;
      end else begin
         m_v_ff   <= dl_v_ff[LAT-1];
         s_v_ff   <= m_v_ff;
         ovl_v_ff <= s_v_ff;
      end
   end

   assign busy = rd_v_ff | (|dl_busy) | m_v_ff | s_v_ff | ovl_v_ff;

   // checks
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == voc_pkg::ST_SCAN |-> issue_ff <= n_ff)
      else $error("scan index beyond obstacle count");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == voc_pkg::ST_IDLE |-> !busy)
      else $error("obstacle pipeline busy while idle");

   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> state_ff == voc_pkg::ST_IDLE && q_item.cmd == voc_pkg::CMD_LOAD)
      else $error("table write outside a load");

   a_result_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_v_ff) |-> $past(state_ff) == voc_pkg::ST_DRAIN)
      else $error("result raised outside the end of a query");

endmodule
`default_nettype wire
